// File: rtl/tst_pkg.sv
package tst_pkg;

    localparam int NUM_SLOTS_DEF  = 8;
    localparam int COORD_BITS_DEF = 12;
    localparam int FIELD_W        = 12;
    localparam int RADIUS_W       = 12;
    localparam int LIMIT_W        = 2 * RADIUS_W;
    localparam int SLOT_FIELD_W   = 3;
    localparam int SLOT_FIELD_MAX = 8;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd64;

    localparam logic [1:0] KIND_DOWN = 2'd0;
    localparam logic [1:0] KIND_MOVE = 2'd1;
    localparam logic [1:0] KIND_UP   = 2'd2;

    typedef struct packed {
        logic [1:0]              event_kind;
        logic [FIELD_W-1:0]      pos_x;
        logic [FIELD_W-1:0]      pos_y;
        logic                    has_slot;
        logic [SLOT_FIELD_W-1:0] slot_in;
    } tst_event_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot_out;
        logic                    slot_valid;
    } tst_result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } tst_state_t;

endpackage

// File: rtl/tst_ram.sv
module tst_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/touch_slot_tracker_unit.sv
// Tagged or down transaction: result strobe in the cycle after start, then back to idle for the next start.
// Untagged move or up transaction: walks every usable slot through the position RAM, one read a cycle,
// then two pipeline stages (p1, p2) and a write-back in ST_WRITE, where the result is strobed; the next
// start is taken only once idle again, as the single read port of the position RAM serves the scan.
// Results are strobed for one cycle and cannot be stalled.
// Reset (rst_n, async, active low): all slots free, grouping_radius 64, FSM idle.
module touch_slot_tracker_unit #(
    parameter int NUM_SLOTS  = tst_pkg::NUM_SLOTS_DEF,
    parameter int COORD_BITS = tst_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  tst_pkg::tst_event_t          touch,
    input  logic                         cfg_we,
    input  logic [tst_pkg::RADIUS_W-1:0] cfg_wdata,
    output logic                         done,
    output tst_pkg::tst_result_t         result
);

    import tst_pkg::*;

    localparam int USABLE = (NUM_SLOTS < SLOT_FIELD_MAX) ? NUM_SLOTS : SLOT_FIELD_MAX;
    localparam int IDX_W  = (USABLE > 1) ? $clog2(USABLE) : 1;
    localparam int CW     = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int SQ_W   = 2 * CW;
    localparam int DIST_W = (SQ_W + 1 > LIMIT_W) ? SQ_W + 1 : LIMIT_W;

    tst_state_t state_reg, state_next;

    logic [RADIUS_W-1:0] radius_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [1:0]          kind_reg;
    logic [CW-1:0]       x_reg, y_reg;
    logic [USABLE-1:0]   active_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                p1_vld_reg;
    logic [IDX_W-1:0]    p1_idx_reg;
    logic                p2_vld_reg;
    logic                p2_act_reg;
    logic [IDX_W-1:0]    p2_idx_reg;
    logic [SQ_W-1:0]     p2_sqx_reg, p2_sqy_reg;
    logic [DIST_W-1:0]   best_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    slot_reg;

    logic                accept;
    logic                tag_ok;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic [SQ_W-1:0]     rdata;
    logic [CW-1:0]       rx, ry, dx, dy;
    logic [DIST_W-1:0]   dist_sum;
    logic                hit;
    logic                wr_en;

    assign accept = start && (state_reg == ST_IDLE);
    assign tag_ok = {1'b0, touch.slot_in} < (SLOT_FIELD_W + 1)'(USABLE);

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = USABLE - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (touch.has_slot || touch.event_kind == KIND_DOWN)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_idx_reg == IDX_W'(USABLE - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!p1_vld_reg)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign wr_en = (state_reg == ST_WRITE) && found_reg;

    tst_ram #(
        .WIDTH (SQ_W),
        .DEPTH (USABLE),
        .AW    (IDX_W)
    ) u_pos_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (slot_reg),
        .wdata ({x_reg, y_reg}),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    assign rx = rdata[SQ_W-1:CW];
    assign ry = rdata[CW-1:0];
    assign dx = (rx >= x_reg) ? rx - x_reg : x_reg - rx;
    assign dy = (ry >= y_reg) ? ry - y_reg : y_reg - ry;

    assign dist_sum = DIST_W'({1'b0, p2_sqx_reg} + {1'b0, p2_sqy_reg});
    assign hit      = p2_vld_reg && p2_act_reg && (dist_sum <= DIST_W'(limit_reg))
                      && (!found_reg || dist_sum < best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            active_reg <= '0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end

            p1_vld_reg <= (state_reg == ST_SCAN);
            p2_vld_reg <= p1_vld_reg;

            if (accept)
            begin
                rd_idx_reg <= '0;
                if (touch.has_slot)
                begin
                    found_reg <= tag_ok;
                end
                else if (touch.event_kind == KIND_DOWN)
                begin
                    found_reg <= free_found;
                end
                else
                begin
                    found_reg <= 1'b0;
                end
            end
            else if (state_reg == ST_SCAN)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end

            if (hit)
            begin
                found_reg <= 1'b1;
            end

            if (wr_en)
            begin
                active_reg[slot_reg] <= (kind_reg != KIND_UP);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= touch.event_kind;
            x_reg     <= touch.pos_x[CW-1:0];
            y_reg     <= touch.pos_y[CW-1:0];
            limit_reg <= LIMIT_W'(radius_reg) * LIMIT_W'(radius_reg);
            slot_reg  <= touch.has_slot ? touch.slot_in[IDX_W-1:0] : free_idx;
        end
        else if (hit)
        begin
            slot_reg <= p2_idx_reg;
            best_reg <= dist_sum;
        end

        p1_idx_reg <= rd_idx_reg;
        p2_idx_reg <= p1_idx_reg;
        p2_act_reg <= active_reg[p1_idx_reg];
        p2_sqx_reg <= SQ_W'(dx) * SQ_W'(dx);
        p2_sqy_reg <= SQ_W'(dy) * SQ_W'(dy);
    end

    assign busy              = (state_reg != ST_IDLE);
    assign done              = (state_reg == ST_WRITE);
    assign result.slot_valid = found_reg;
    assign result.slot_out   = found_reg ? SLOT_FIELD_W'(slot_reg) : '0;

endmodule

// File: rtl/tst_checker.sv
module tst_checker #(
    parameter int NUM_SLOTS = tst_pkg::NUM_SLOTS_DEF
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input tst_pkg::tst_event_t  touch,
    input logic                 done,
    input tst_pkg::tst_result_t result
);

    import tst_pkg::*;

    // accepted transaction holds the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after accepted transaction");

    // return to idle right after the result strobe
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy held after result");

    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    a_unassigned_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.slot_valid) |-> (result.slot_out == '0))
        else $error("unassigned result carries a slot");

    // tagged in-range event comes back on its own slot in the next cycle
    a_tagged: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && touch.has_slot && (NUM_SLOTS > SLOT_FIELD_MAX
            || 32'(touch.slot_in) < NUM_SLOTS))
        |=> (done && result.slot_valid && result.slot_out == $past(touch.slot_in)))
        else $error("tagged transaction mis-assigned");

endmodule

bind touch_slot_tracker_unit tst_checker #(.NUM_SLOTS(NUM_SLOTS)) u_tst_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .touch  (touch),
    .done   (done),
    .result (result)
);
